// File: src/rc4_pkg.sv
// Shared types, operation codes and constants for the RC4 cipher block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rc4_pkg;

	localparam int MAX_KEY_BYTES_DEF = 16;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 64;
	localparam int KEY_LEN_W         = 5;
	localparam int OP_W              = 4;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 5'd16;

	localparam logic KIND_RESTART = 1'b0;
	localparam logic KIND_DATA    = 1'b1;

	// datapath operations
	localparam logic [OP_W-1:0] OP_IDLE   = 4'd0;  // read s[i+1], no update
	localparam logic [OP_W-1:0] OP_START  = 4'd1;  // clear schedule counters
	localparam logic [OP_W-1:0] OP_STEP_I = 4'd2;  // i <= i+1, read s[i+1]
	localparam logic [OP_W-1:0] OP_INIT   = 4'd3;  // s[n] <= n
	localparam logic [OP_W-1:0] OP_K_RDN  = 4'd4;
	localparam logic [OP_W-1:0] OP_K_RDJ  = 4'd5;
	localparam logic [OP_W-1:0] OP_K_WRN  = 4'd6;
	localparam logic [OP_W-1:0] OP_K_WRJ  = 4'd7;
	localparam logic [OP_W-1:0] OP_G_RDJ  = 4'd8;
	localparam logic [OP_W-1:0] OP_G_WRI  = 4'd9;
	localparam logic [OP_W-1:0] OP_G_WRJ  = 4'd10;
	localparam logic [OP_W-1:0] OP_G_OUT  = 4'd11;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_in;
		logic       end_of_record;
	} in_word_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       record_end;
	} out_word_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            latch;     // capture the input word
		logic            out_load;  // load the output register
	} cmd_t;

	typedef struct packed {
		logic n_last;   // schedule counter at 255
		logic rec_end;  // held end-of-record mark
	} stat_t;

endpackage

`default_nettype wire

// File: src/rc4_dp.sv
// RC4 datapath: sbox memory, schedule and generator indices, output register.
// Depends on rc4_pkg; driven by rc4_ctrl through cmd_t.
`default_nettype none

module rc4_dp import rc4_pkg::*; #(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output stat_t                      stat,
	input  wire in_word_t              in_word,
	input  wire logic [CFG_DATA_W-1:0] key_low,
	input  wire logic [CFG_DATA_W-1:0] key_high,
	input  wire logic [KEY_LEN_W-1:0]  key_len,
	output out_word_t                  out_word
);

	localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

	logic [7:0] sbox_mem [256];
	logic [7:0] rdata_q;
	logic [7:0] raddr;
	logic       we;
	logic [7:0] waddr;
	logic [7:0] wdata;

	logic [7:0]        n_q;
	logic [KIDX_W-1:0] kidx_q;
	logic [7:0]        i_q;
	logic [7:0]        j_q;
	logic [7:0]        si_q;
	logic [7:0]        sj_q;
	logic              byp_q;
	logic [7:0]        data_q;
	logic              eor_q;
	out_word_t         out_q;

	logic [2*CFG_DATA_W-1:0] key_vec;
	logic [7:0]              key_byte;
	logic [KEY_LEN_W-1:0]    len_eff;
	logic [KEY_LEN_W-1:0]    len_m1;
	logic [7:0]              i_nxt;
	logic [7:0]              jk_nxt;
	logic [7:0]              jg_nxt;
	logic [7:0]              t_addr;
	logic [7:0]              ks_byte;

	assign key_vec  = {key_high, key_low};
	assign key_byte = key_vec[8*kidx_q +: 8];
	assign len_eff  = (key_len == '0) ? KEY_LEN_W'(1) :
	                  (key_len > MAX_LEN) ? MAX_LEN : key_len;
	assign len_m1   = len_eff - KEY_LEN_W'(1);
	assign i_nxt    = i_q + 8'd1;
	assign jk_nxt   = j_q + rdata_q + key_byte;
	assign jg_nxt   = j_q + rdata_q;
	assign t_addr   = si_q + sj_q;
	// s[j] was just rewritten with s[i] when t lands on j
	assign ks_byte  = byp_q ? si_q : rdata_q;

	always_comb begin
		raddr = i_nxt;
		we    = 1'b0;
		waddr = n_q;
		wdata = n_q;
		case (cmd.op)
			OP_INIT: begin
				we = 1'b1;
			end
			OP_K_RDN: begin
				raddr = n_q;
			end
			OP_K_RDJ: begin
				raddr = jk_nxt;
			end
			OP_K_WRN: begin
				we    = 1'b1;
				wdata = rdata_q;
			end
			OP_K_WRJ: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = si_q;
			end
			OP_G_RDJ: begin
				raddr = jg_nxt;
			end
			OP_G_WRI: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = rdata_q;
			end
			OP_G_WRJ: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = si_q;
				raddr = t_addr;
			end
			OP_G_OUT: begin
				raddr = t_addr;
			end
			default: begin
				raddr = i_nxt;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			sbox_mem[waddr] <= wdata;
		end
		rdata_q <= sbox_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			kidx_q <= '0;
			i_q    <= '0;
			j_q    <= '0;
		end else begin
			case (cmd.op)
				OP_START: begin
					n_q    <= '0;
					kidx_q <= '0;
					j_q    <= '0;
				end
				OP_STEP_I: begin
					i_q <= i_nxt;
				end
				OP_INIT: begin
					n_q <= n_q + 8'd1;
				end
				OP_K_RDJ: begin
					j_q <= jk_nxt;
				end
				OP_K_WRJ: begin
					n_q    <= n_q + 8'd1;
					kidx_q <= (KEY_LEN_W'(kidx_q) == len_m1) ? '0 : kidx_q + 1'b1;
					if (n_q == 8'hFF) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				OP_G_RDJ: begin
					j_q <= jg_nxt;
				end
				default: begin
					n_q <= n_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			data_q <= in_word.data_in;
			eor_q  <= in_word.end_of_record;
		end
		if (cmd.op == OP_K_RDJ || cmd.op == OP_G_RDJ) begin
			si_q <= rdata_q;
		end
		if (cmd.op == OP_G_WRI) begin
			sj_q <= rdata_q;
		end
		if (cmd.op == OP_G_WRJ) begin
			byp_q <= (t_addr == j_q);
		end
		if (cmd.out_load) begin
			out_q.data_out   <= data_q ^ ks_byte;
			out_q.record_end <= eor_q;
		end
	end

	assign stat.n_last  = (n_q == 8'hFF);
	assign stat.rec_end = eor_q;
	assign out_word     = out_q;

endmodule

`default_nettype wire

// File: src/rc4_ctrl.sv
// RC4 controller: sequences key schedule and generator steps, owns handshakes.
// Depends on rc4_pkg; commands rc4_dp through cmd_t, reads stat_t.
`default_nettype none

module rc4_ctrl import rc4_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire logic  in_kind,
	output logic       out_valid,
	input  wire logic  out_ready,
	output cmd_t       cmd,
	input  wire stat_t stat
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_INIT = 4'd1;
	localparam logic [3:0] ST_KRN  = 4'd2;
	localparam logic [3:0] ST_KRJ  = 4'd3;
	localparam logic [3:0] ST_KWN  = 4'd4;
	localparam logic [3:0] ST_KWJ  = 4'd5;
	localparam logic [3:0] ST_GRI  = 4'd6;
	localparam logic [3:0] ST_GRJ  = 4'd7;
	localparam logic [3:0] ST_GWI  = 4'd8;
	localparam logic [3:0] ST_GWJ  = 4'd9;
	localparam logic [3:0] ST_GOUT = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       keyed_q;
	logic       pend_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt    = state_q;
		cmd.op       = OP_IDLE;
		cmd.latch    = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.latch = 1'b1;
					if (in_kind == KIND_RESTART || !keyed_q) begin
						cmd.op    = OP_START;
						state_nxt = ST_INIT;
					end else begin
						cmd.op    = OP_STEP_I;
						state_nxt = ST_GRJ;
					end
				end
			end
			ST_INIT: begin
				cmd.op = OP_INIT;
				if (stat.n_last) begin
					state_nxt = ST_KRN;
				end
			end
			ST_KRN: begin
				cmd.op    = OP_K_RDN;
				state_nxt = ST_KRJ;
			end
			ST_KRJ: begin
				cmd.op    = OP_K_RDJ;
				state_nxt = ST_KWN;
			end
			ST_KWN: begin
				cmd.op    = OP_K_WRN;
				state_nxt = ST_KWJ;
			end
			ST_KWJ: begin
				cmd.op = OP_K_WRJ;
				if (!stat.n_last) begin
					state_nxt = ST_KRN;
				end else if (pend_q) begin
					state_nxt = ST_GRI;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_GRI: begin
				cmd.op    = OP_STEP_I;
				state_nxt = ST_GRJ;
			end
			ST_GRJ: begin
				cmd.op    = OP_G_RDJ;
				state_nxt = ST_GWI;
			end
			ST_GWI: begin
				cmd.op    = OP_G_WRI;
				state_nxt = ST_GWJ;
			end
			ST_GWJ: begin
				cmd.op    = OP_G_WRJ;
				state_nxt = ST_GOUT;
			end
			ST_GOUT: begin
				cmd.op       = OP_G_OUT;
				cmd.out_load = out_free;
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			keyed_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				pend_q <= (in_kind == KIND_DATA);
			end
			if (state_q == ST_KWJ && stat.n_last) begin
				keyed_q <= 1'b1;
			end else if (cmd.out_load && stat.rec_end) begin
				// record closed: next data word rekeys
				keyed_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/rc4_stream_cipher.sv
// RC4 stream cipher, top level. Data word when keyed: steps follow the sbox
// memory, one read and one write port (read s[i], read s[j], write s[i], write
// s[j] and read s[t]); the next word is taken only once the result is loaded.
// Key schedule (restart, or first data word after reset or end of record):
// 256 fill writes, then per swap step read s[n], read s[j], write s[n], s[j].
// Async active-low reset clears control state; key_length resets to 16.
`default_nettype none

module rc4_stream_cipher import rc4_pkg::*; #(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_word_t              in_word,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_word_t                  out_word,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CFG_DATA_W-1:0] key_low_q;
	logic [CFG_DATA_W-1:0] key_high_q;
	logic [KEY_LEN_W-1:0]  key_len_q;
	cmd_t                  cmd;
	stat_t                 stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= KEY_LEN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LEN:  key_len_q  <= cfg_data[KEY_LEN_W-1:0];
				default:      key_len_q  <= key_len_q;
			endcase
		end
	end

	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_kind   (in_word.kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	rc4_dp #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_word  (in_word),
		.key_low  (key_low_q),
		.key_high (key_high_q),
		.key_len  (key_len_q),
		.out_word (out_word)
	);

endmodule

`default_nettype wire
